[rtl/sbs_pkg.sv]
// shared types, constants and codes of the speed band supervisor
// no dependencies; imported by every module of the block
package sbs_pkg;

  // tone counter periods
  localparam logic [7:0] ALARM_TICKS = 8'd25;
  localparam logic [7:0] WARN_TICKS  = 8'd50;

  // 30 km/h in Q8.8 m/s, setpoint when a car is near ahead
  localparam logic [15:0] SLOW_SET = 16'd2133;

  // datapath widths
  localparam int unsigned NUM_W  = 48;
  localparam int unsigned DEN_W  = 42;
  localparam int unsigned REM_W  = DEN_W + 1;
  localparam int unsigned ACC_W  = 52;
  localparam int unsigned E_W    = 34;
  localparam int unsigned D_W    = 20;
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned ROOT_W = 16;
  localparam int unsigned SREM_W = ROOT_W + 2;
  localparam int unsigned CNT_W  = 6;

  // sequencer step counts
  localparam int unsigned PRE_STEPS  = 4;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned POST_STEPS = 3;

  // normalized error below 0.1 uses the plain acceleration d term
  localparam logic signed [E_W-1:0] E_SMALL       = 34'sd6554;
  // ceil(2^28 / 25): root * 128 / 25 == (root * D_SMALL_RECIP) >> 21
  localparam logic [23:0]           D_SMALL_RECIP = 24'd10737419;
  localparam logic [12:0]           CMD_FULL      = 13'd4096;

  // tone codes
  localparam logic [1:0] TONE_NONE  = 2'd0;
  localparam logic [1:0] TONE_WARN  = 2'd1;
  localparam logic [1:0] TONE_ALARM = 2'd2;

  // band codes
  localparam logic [2:0] BAND_FAR_BELOW = 3'd0;
  localparam logic [2:0] BAND_BELOW_MIN = 3'd1;
  localparam logic [2:0] BAND_ABOVE_MIN = 3'd2;
  localparam logic [2:0] BAND_BELOW_MAX = 3'd3;
  localparam logic [2:0] BAND_ABOVE_MAX = 3'd4;
  localparam logic [2:0] BAND_FAR_ABOVE = 3'd5;
  localparam logic [2:0] BAND_COMFORT   = 3'd6;

  // register indexes
  localparam logic [2:0] REG_LO_LIMIT   = 3'd0;
  localparam logic [2:0] REG_HI_LIMIT   = 3'd1;
  localparam logic [2:0] REG_MARGIN     = 3'd2;
  localparam logic [2:0] REG_GAIN_P     = 3'd3;
  localparam logic [2:0] REG_GAIN_I     = 3'd4;
  localparam logic [2:0] REG_GAIN_D     = 3'd5;
  localparam logic [2:0] REG_INT_WINDOW = 3'd6;
  localparam logic [2:0] REG_NEAR_GAP   = 3'd7;

  typedef struct packed {
    logic [15:0] lo_limit;
    logic [15:0] hi_limit;
    logic [15:0] speed_margin;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] integral_window;
    logic [15:0] near_gap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    lo_limit:        16'd4267,
    hi_limit:        16'd8533,
    speed_margin:    16'd356,
    gain_p:          16'd256,
    gain_i:          16'd0,
    gain_d:          16'd0,
    integral_window: 16'd512,
    near_gap:        16'd3456
  };

  // multiply-accumulate operations
  typedef enum logic [2:0] {
    MOP_AXAX = 3'd0,
    MOP_AYAY = 3'd1,
    MOP_AXSX = 3'd2,
    MOP_AYSY = 3'd3,
    MOP_EGP  = 3'd4,
    MOP_DGD  = 3'd5,
    MOP_IGI  = 3'd6
  } mop_e;

  typedef struct packed {
    logic capture;
    logic classify;
    logic mop_en;
    mop_e mop;
    logic sqrt_step;
    logic div_init_e;
    logic div_step;
    logic e_load;
    logic integ;
    logic d_load;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pid_req;
  } sts_t;

endpackage

[rtl/sbs_regs.sv]
// configuration register file behind the apb-style port
// depends on sbs_pkg
module sbs_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output sbs_pkg::cfg_t cfg_o
);
  import sbs_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_LO_LIMIT:   cfg_d.lo_limit        = pwdata[15:0];
        REG_HI_LIMIT:   cfg_d.hi_limit        = pwdata[15:0];
        REG_MARGIN:     cfg_d.speed_margin    = pwdata[15:0];
        REG_GAIN_P:     cfg_d.gain_p          = pwdata[15:0];
        REG_GAIN_I:     cfg_d.gain_i          = pwdata[15:0];
        REG_GAIN_D:     cfg_d.gain_d          = pwdata[15:0];
        REG_INT_WINDOW: cfg_d.integral_window = pwdata[15:0];
        REG_NEAR_GAP:   cfg_d.near_gap        = pwdata[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_LO_LIMIT:   prdata = {16'd0, cfg_q.lo_limit};
      REG_HI_LIMIT:   prdata = {16'd0, cfg_q.hi_limit};
      REG_MARGIN:     prdata = {16'd0, cfg_q.speed_margin};
      REG_GAIN_P:     prdata = {16'd0, cfg_q.gain_p};
      REG_GAIN_I:     prdata = {16'd0, cfg_q.gain_i};
      REG_GAIN_D:     prdata = {16'd0, cfg_q.gain_d};
      REG_INT_WINDOW: prdata = {16'd0, cfg_q.integral_window};
      REG_NEAR_GAP:   prdata = {16'd0, cfg_q.near_gap};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/sbs_ctrl.sv]
// sequencer: steps the datapath through classify, sqrt, divides and sums
// depends on sbs_pkg
module sbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  sbs_pkg::sts_t sts_i,
  output sbs_pkg::cmd_t cmd_o
);
  import sbs_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_CLASSIFY = 11'b000_0000_0010,
    ST_MUL_PRE  = 11'b000_0000_0100,
    ST_SQRT     = 11'b000_0000_1000,
    ST_DIV_E    = 11'b000_0001_0000,
    ST_E_LOAD   = 11'b000_0010_0000,
    ST_INTEG    = 11'b000_0100_0000,
    ST_DIV_D    = 11'b000_1000_0000,
    ST_D_LOAD   = 11'b001_0000_0000,
    ST_MUL_POST = 11'b010_0000_0000,
    ST_FINISH   = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mop = MOP_AXAX;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        cnt_d = '0;
        state_d = sts_i.pid_req ? ST_MUL_PRE : ST_FINISH;
      end
      ST_MUL_PRE: begin
        cmd_o.mop_en = 1'b1;
        unique case (cnt_q[1:0])
          2'd0: begin
            cmd_o.mop = MOP_AXAX;
            cmd_o.div_init_e = 1'b1;
          end
          2'd1: cmd_o.mop = MOP_AYAY;
          2'd2: cmd_o.mop = MOP_AXSX;
          default: cmd_o.mop = MOP_AYSY;
        endcase
        if (cnt_q == CNT_W'(PRE_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_DIV_E;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV_E: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_E_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_E_LOAD: begin
        cmd_o.e_load = 1'b1;
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.integ = 1'b1;
        cnt_d = '0;
        state_d = ST_DIV_D;
      end
      ST_DIV_D: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_D_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_D_LOAD: begin
        cmd_o.d_load = 1'b1;
        cnt_d = '0;
        state_d = ST_MUL_POST;
      end
      ST_MUL_POST: begin
        cmd_o.mop_en = 1'b1;
        unique case (cnt_q[1:0])
          2'd0:    cmd_o.mop = MOP_EGP;
          2'd1:    cmd_o.mop = MOP_DGD;
          default: cmd_o.mop = MOP_IGI;
        endcase
        if (cnt_q == CNT_W'(POST_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/sbs_datapath.sv]
// datapath: band classifier, tone counter, shared mac, sqrt and divider units
// depends on sbs_pkg; driven by sbs_ctrl commands
module sbs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbs_pkg::cfg_t      cfg_i,
  input  sbs_pkg::cmd_t      cmd_i,
  output sbs_pkg::sts_t      sts_o,
  input  logic signed [15:0] vel_long_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] speed_x_i,
  input  logic signed [15:0] speed_y_i,
  input  logic signed [15:0] front_gap_i,
  output logic               pid_applied_o,
  output logic [12:0]        accel_cmd_o,
  output logic [12:0]        brake_cmd_o,
  output logic [1:0]         tone_o,
  output logic [2:0]         band_o
);
  import sbs_pkg::*;

  // captured request
  logic signed [15:0] v_q, ax_q, ay_q, sx_q, sy_q, gap_q;

  // classification
  logic signed [18:0] v_x, mn_x, mx_x, m_x, slow_x;
  logic signed [16:0] gap_x, near_x;
  logic               near, alarm, pid_d;
  logic [2:0]         band_d;
  logic [1:0]         tone_d;
  logic [15:0]        sp_raw, sp_d;
  logic [7:0]         period, cnt_d;
  logic [7:0]         sound_count_q;
  logic [2:0]         band_q;
  logic [1:0]         tone_q;
  logic               pid_q;
  logic [15:0]        sp_q;

  // mac
  logic signed [16:0]      mul_a;
  logic signed [E_W-1:0]   mul_b;
  logic signed [50:0]      prod;
  logic signed [ACC_W-1:0] prod_x, acc_base, acc_sum, acc_q;
  logic [SQ_W-1:0]         sq_q;
  logic                    dot_neg_q;

  // sqrt
  logic [SREM_W-1:0]   srem_q;
  logic [SREM_W+1:0]   srem_sh, trial;
  logic [ROOT_W-1:0]   root_q;

  // divider
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [REM_W-1:0]  rem_q, rem_sh;
  logic              div_ge;

  // error, d term, integral
  logic signed [17:0]    diff;
  logic [16:0]           diff_mag;
  logic signed [E_W-1:0] e_q;
  logic                  e_neg_q, d_neg_q, small_e;
  logic [E_W-2:0]        e_mag;
  logic [E_W+9:0]        e_k;
  logic [39:0]           d_recip;
  logic [D_W-1:0]        d_mag_sel;
  logic signed [D_W-1:0] d_q;
  logic signed [31:0]    error_integral_q;
  logic signed [34:0]    int_sum;
  logic                  in_win;

  // output
  logic               pos;
  logic [ACC_W-1:0]   mag_src;
  logic [ACC_W-13:0]  mag;
  logic [12:0]        sat;

  assign sts_o.pid_req = pid_d;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q   <= vel_long_i;
      ax_q  <= accel_x_i;
      ay_q  <= accel_y_i;
      sx_q  <= speed_x_i;
      sy_q  <= speed_y_i;
      gap_q <= front_gap_i;
    end
  end

  // band classification
  assign v_x    = {{3{v_q[15]}}, v_q};
  assign mn_x   = {3'b000, cfg_i.lo_limit};
  assign mx_x   = {3'b000, cfg_i.hi_limit};
  assign m_x    = {3'b000, cfg_i.speed_margin};
  assign slow_x = {3'b000, SLOW_SET};
  assign gap_x  = {gap_q[15], gap_q};
  assign near_x = {1'b0, cfg_i.near_gap};
  assign near   = (gap_x > 17'sd0) && (gap_x < near_x);

  always_comb begin
    band_d = BAND_COMFORT;
    alarm  = 1'b1;
    pid_d  = 1'b0;
    sp_raw = cfg_i.lo_limit;
    priority if (v_x < mn_x - m_x) begin
      band_d = BAND_FAR_BELOW;
      if (!near) begin
        pid_d = 1'b1;
      end else if (v_x <= slow_x) begin
        pid_d  = 1'b1;
        sp_raw = SLOW_SET;
      end
    end else if (v_x < mn_x) begin
      band_d = BAND_BELOW_MIN;
    end else if (v_x < mn_x + m_x) begin
      band_d = BAND_ABOVE_MIN;
      alarm  = 1'b0;
    end else if ((mx_x - m_x < v_x) && (v_x <= mx_x)) begin
      band_d = BAND_BELOW_MAX;
      alarm  = 1'b0;
    end else if ((mx_x < v_x) && (v_x <= mx_x + m_x)) begin
      band_d = BAND_ABOVE_MAX;
    end else if (mx_x + m_x < v_x) begin
      band_d = BAND_FAR_ABOVE;
      pid_d  = 1'b1;
      sp_raw = cfg_i.hi_limit;
    end else begin
      band_d = BAND_COMFORT;
    end
    sp_d = (sp_raw == 16'd0) ? 16'd1 : sp_raw;
  end

  // tone counter
  always_comb begin
    period = alarm ? ALARM_TICKS : WARN_TICKS;
    priority if (band_d == BAND_COMFORT) begin
      cnt_d  = 8'd0;
      tone_d = TONE_NONE;
    end else if (sound_count_q > period) begin
      cnt_d  = 8'd0;
      tone_d = alarm ? TONE_ALARM : TONE_WARN;
    end else begin
      cnt_d  = sound_count_q + 8'd1;
      tone_d = TONE_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      band_q <= band_d;
      tone_q <= tone_d;
      pid_q  <= pid_d;
      sp_q   <= sp_d;
    end
  end

  // multiply-accumulate operand select
  always_comb begin
    unique case (cmd_i.mop)
      MOP_AXAX: begin
        mul_a = {ax_q[15], ax_q};
        mul_b = {{(E_W-16){ax_q[15]}}, ax_q};
      end
      MOP_AYAY: begin
        mul_a = {ay_q[15], ay_q};
        mul_b = {{(E_W-16){ay_q[15]}}, ay_q};
      end
      MOP_AXSX: begin
        mul_a = {ax_q[15], ax_q};
        mul_b = {{(E_W-16){sx_q[15]}}, sx_q};
      end
      MOP_AYSY: begin
        mul_a = {ay_q[15], ay_q};
        mul_b = {{(E_W-16){sy_q[15]}}, sy_q};
      end
      MOP_EGP: begin
        mul_a = {1'b0, cfg_i.gain_p};
        mul_b = e_q;
      end
      MOP_DGD: begin
        mul_a = {1'b0, cfg_i.gain_d};
        mul_b = {{(E_W-D_W){d_q[D_W-1]}}, d_q};
      end
      MOP_IGI: begin
        mul_a = {1'b0, cfg_i.gain_i};
        mul_b = {{(E_W-32){error_integral_q[31]}}, error_integral_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod   = mul_a * mul_b;
    prod_x = {prod[50], prod};
    acc_base = ((cmd_i.mop == MOP_AXAX) || (cmd_i.mop == MOP_AXSX) ||
                (cmd_i.mop == MOP_EGP)) ? '0 : acc_q;
    acc_sum = acc_base + prod_x;
  end

  // sqrt step, two radicand bits per cycle
  assign srem_sh = {srem_q, sq_q[SQ_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mop_en) begin
      acc_q <= acc_sum;
      if (cmd_i.mop == MOP_AYAY) begin
        sq_q   <= acc_sum[SQ_W-1:0];
        srem_q <= '0;
        root_q <= '0;
      end
      if (cmd_i.mop == MOP_AYSY) begin
        dot_neg_q <= acc_sum[ACC_W-1];
      end
    end else if (cmd_i.sqrt_step) begin
      sq_q <= {sq_q[SQ_W-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem_q <= SREM_W'(srem_sh - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= SREM_W'(srem_sh);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // speed error against setpoint
  assign diff     = $signed({2'b00, sp_q}) - $signed({{2{v_q[15]}}, v_q});
  assign diff_mag = diff[17] ? 17'(-diff) : diff[16:0];
  assign in_win   = diff_mag < {1'b0, cfg_i.integral_window};

  // d term divisor prep
  assign small_e = (e_q > -E_SMALL) && (e_q < E_SMALL);
  assign e_mag   = e_q[E_W-1] ? (E_W-1)'(-e_q) : e_q[E_W-2:0];
  assign e_k     = ({e_mag, 10'd0}) - ({4'd0, e_mag, 6'd0} >> 2) - ({4'd0, e_mag, 6'd0} >> 3);

  // small-error d term: root * 128 / 25 by reciprocal multiply
  assign d_recip   = root_q * D_SMALL_RECIP;
  assign d_mag_sel = small_e ? {1'b0, d_recip[39:21]} : num_q[D_W-1:0];

  // restoring divider
  assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign div_ge = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init_e) begin
      num_q   <= NUM_W'({diff_mag, 16'd0});
      den_q   <= DEN_W'(sp_q);
      rem_q   <= '0;
      e_neg_q <= diff[17];
    end else if (cmd_i.integ) begin
      rem_q   <= '0;
      d_neg_q <= dot_neg_q ^ (!small_e & e_q[E_W-1]);
      num_q   <= NUM_W'({root_q, 25'd0});
      den_q   <= DEN_W'(e_k);
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], div_ge};
      rem_q <= div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  // quotient sign fix-up
  always_ff @(posedge clk_i) begin
    if (cmd_i.e_load) begin
      e_q <= e_neg_q ? -$signed(num_q[E_W-1:0]) : $signed(num_q[E_W-1:0]);
    end
    if (cmd_i.d_load) begin
      d_q <= d_neg_q ? -$signed(d_mag_sel) : $signed(d_mag_sel);
    end
  end

  // saturating integral
  assign int_sum = {{3{error_integral_q[31]}}, error_integral_q} + {e_q[E_W-1], e_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_integral_q <= '0;
      sound_count_q    <= '0;
    end else begin
      if (cmd_i.classify) begin
        sound_count_q <= cnt_d;
      end
      if (cmd_i.integ && in_win) begin
        priority if (int_sum > 35'sd2147483647) begin
          error_integral_q <= 32'sh7FFF_FFFF;
        end else if (int_sum < -35'sd2147483648) begin
          error_integral_q <= 32'sh8000_0000;
        end else begin
          error_integral_q <= int_sum[31:0];
        end
      end
    end
  end

  // command saturation
  assign pos     = !acc_q[ACC_W-1] && (acc_q != '0);
  assign mag_src = pos ? acc_q : ACC_W'(-acc_q);
  assign mag     = mag_src[ACC_W-1:12];
  assign sat     = (mag > (ACC_W-12)'(CMD_FULL)) ? CMD_FULL : mag[12:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      band_o        <= band_q;
      tone_o        <= tone_q;
      pid_applied_o <= pid_q;
      accel_cmd_o   <= (pid_q && pos) ? sat : 13'd0;
      brake_cmd_o   <= (pid_q && !pos) ? sat : 13'd0;
    end
  end

endmodule

[rtl/speed_band_supervisor_pid.sv]
// top level of the speed band supervisor with pid pull-up and pull-down
// depends on sbs_pkg, sbs_regs, sbs_ctrl, sbs_datapath
//
// usage:
//  request channel: in_valid_i / in_stall_o with six q8.8 fields per tick
//  result channel:  out_valid_o / out_stall_i, one result per request
//  apb-style port sets limits, margin, gains, integral window, near gap
// a tick with no pid runs classify and finish after acceptance; a pid tick also
//  runs 4 mac, 16 sqrt, two 48-step divides and 3 mac steps, with load and
//  integral steps between them; a new request is taken only once the sequencer
//  is idle again, so with pid the bit-serial divisions of the shared divider set the pace
// a new request is taken while the previous result waits in the output
//  register; the finished result of that request holds until the register
//  is free, so a stalled receiver stalls the request side after one item
// reset clears the integral, the tone counter, the sequencer and output valid,
//  and reloads the configuration defaults
module speed_band_supervisor_pid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] vel_long_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] speed_x_i,
  input  logic signed [15:0] speed_y_i,
  input  logic signed [15:0] front_gap_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               pid_applied_o,
  output logic [12:0]        accel_cmd_o,
  output logic [12:0]        brake_cmd_o,
  output logic [1:0]         tone_o,
  output logic [2:0]         band_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sbs_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  sbs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  sbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic
  sbs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .vel_long_i    (vel_long_i),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .speed_x_i     (speed_x_i),
    .speed_y_i     (speed_y_i),
    .front_gap_i   (front_gap_i),
    .pid_applied_o (pid_applied_o),
    .accel_cmd_o   (accel_cmd_o),
    .brake_cmd_o   (brake_cmd_o),
    .tone_o        (tone_o),
    .band_o        (band_o)
  );

endmodule

[rtl/sbs_checker.sv]
// port-level checks of the speed band supervisor, bound to the top level
// depends on sbs_pkg and speed_band_supervisor_pid
module sbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        pid_applied_o,
  input logic [12:0] accel_cmd_o,
  input logic [12:0] brake_cmd_o,
  input logic [1:0]  tone_o,
  input logic [2:0]  band_o
);
  import sbs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(band_o) &&
    $stable(accel_cmd_o) && $stable(brake_cmd_o) && $stable(tone_o))
    else $error("stalled result changed");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // commands only with pid
  a_no_pid_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pid_applied_o |-> accel_cmd_o == 13'd0 && brake_cmd_o == 13'd0)
    else $error("command without pid");

  // throttle and brake exclusive and saturated
  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accel_cmd_o == 13'd0 || brake_cmd_o == 13'd0) &&
    accel_cmd_o <= CMD_FULL && brake_cmd_o <= CMD_FULL)
    else $error("command out of range");

  // comfortable band is quiet
  a_comfort_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && band_o == BAND_COMFORT |-> tone_o == TONE_NONE && !pid_applied_o)
    else $error("comfortable band with tone or pid");

endmodule

bind speed_band_supervisor_pid sbs_checker u_sbs_checker (.*);
